// ----- rtl/hfrj_pkg.sv -----
// Shared types, constants and helpers for the hyperbola fit residual/Jacobian block.
// No dependencies; used by every file under rtl.
package hfrj_pkg;

   localparam int WORD_W     = 32;
   localparam int SIG_W      = 31;
   localparam int CSR_IDX_W  = 4;

   // divider: quotient bits of (|p| << 16) / |q|, plus input and output stages
   localparam int DIV_BITS   = 48;
   localparam int DIV_LAT    = DIV_BITS + 2;
   // multiplier: product stage and clamp stage
   localparam int MUL_LAT    = 2;
   // square root: one result bit per stage
   localparam int SQRT_STEPS = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH_A  = 4'd0,
      CSR_SCALE_B  = 4'd1,
      CSR_CENTER_C = 4'd2,
      CSR_OFFSET_D = 4'd3
   } csr_index_type;

   localparam logic [WORD_W-1:0] RST_WIDTH_A  = 32'h0001_0000;
   localparam logic [WORD_W-1:0] RST_SCALE_B  = 32'h0002_0000;
   localparam logic [WORD_W-1:0] RST_CENTER_C = 32'h0000_0000;
   localparam logic [WORD_W-1:0] RST_OFFSET_D = 32'h0001_0000;
   localparam logic [WORD_W-1:0] Q_ONE        = 32'h0001_0000;
   localparam logic [WORD_W-1:0] W_MAX        = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0] W_MIN        = 32'h8000_0000;

   // a word with its saturation flag
   typedef struct packed {
      logic [WORD_W-1:0] val;
      logic              sat;
   } sat_word_type;

   // magnitude of a two's complement word (the most negative value fits unsigned)
   function automatic logic [WORD_W-1:0] mag32(input logic [WORD_W-1:0] v);
      return v[WORD_W-1] ? (~v + 32'd1) : v;
   endfunction

   // apply a sign to a 48-bit magnitude and clamp to the signed word range
   function automatic sat_word_type clamp_mag(input logic [DIV_BITS-1:0] m,
                                              input logic neg);
      sat_word_type r;
      if (neg) begin
         if (m > 48'h0000_8000_0000) begin
            r.val = W_MIN;
            r.sat = 1'b1;
         end else begin
            r.val = ~m[WORD_W-1:0] + 32'd1;
            r.sat = 1'b0;
         end
      end else begin
         if (m > 48'h0000_7FFF_FFFF) begin
            r.val = W_MAX;
            r.sat = 1'b1;
         end else begin
            r.val = m[WORD_W-1:0];
            r.sat = 1'b0;
         end
      end
      return r;
   endfunction

endpackage

// ----- rtl/hfrj_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
// Depends on hfrj_pkg.
module hfrj_sqrt (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] radicand,
   output logic [31:0] root
);
   import hfrj_pkg::*;

   logic [33:0] rem_ff  [0:SQRT_STEPS-1];
   logic [33:0] rem_in  [0:SQRT_STEPS-1];
   logic [31:0] root_ff [0:SQRT_STEPS-1];
   logic [31:0] root_in [0:SQRT_STEPS-1];
   logic [63:0] rest_ff [0:SQRT_STEPS-1];
   logic [63:0] rest_in [0:SQRT_STEPS-1];

   // restoring digit recurrence: bring down two radicand bits per stage
   always_comb begin
      logic [33:0] rp;
      logic [31:0] qp;
      logic [63:0] np;
      logic [35:0] sh;
      logic [35:0] trial;
      for (int i = 0; i < SQRT_STEPS; i++) begin
         if (i == 0) begin
            rp = '0;
            qp = '0;
            np = radicand;
         end else begin
            rp = rem_ff[i-1];
            qp = root_ff[i-1];
            np = rest_ff[i-1];
         end
         sh    = {rp, np[63:62]};
         trial = {2'b00, qp, 2'b01};
         if (sh >= trial) begin
            rem_in[i]  = 34'(sh - trial);
            root_in[i] = {qp[30:0], 1'b1};
         end else begin
            rem_in[i]  = sh[33:0];
            root_in[i] = {qp[30:0], 1'b0};
         end
         rest_in[i] = {np[61:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < SQRT_STEPS; i++) begin
            rem_ff[i]  <= rem_in[i];
            root_ff[i] <= root_in[i];
            rest_ff[i] <= rest_in[i];
         end
      end
   end

   assign root = root_ff[SQRT_STEPS-1];

endmodule

// ----- rtl/hfrj_div.sv -----
// Pipelined Q16.16 divider: sign applied to (|p| << 16) / |q|, clamped to a word.
// Depends on hfrj_pkg.
module hfrj_div (
   input  logic                      clock,
   input  logic                      en,
   input  logic [31:0]               num_mag,
   input  logic                      num_neg,
   input  logic [31:0]               den_mag,
   input  logic                      den_neg,
   output hfrj_pkg::sat_word_type    result
);
   import hfrj_pkg::*;

   logic [31:0]         rem_ff [0:DIV_BITS];
   logic [31:0]         rem_in [0:DIV_BITS];
   logic [DIV_BITS-1:0] acc_ff [0:DIV_BITS];
   logic [DIV_BITS-1:0] acc_in [0:DIV_BITS];
   logic [31:0]         den_ff [0:DIV_BITS];
   logic                neg_ff [0:DIV_BITS];
   sat_word_type        result_ff;

   // one quotient bit per stage; acc shifts dividend out and quotient in
   always_comb begin
      logic [32:0] sh;
      logic [32:0] df;
      rem_in[0] = '0;
      acc_in[0] = {num_mag, 16'b0};
      for (int k = 1; k <= DIV_BITS; k++) begin
         sh = {rem_ff[k-1], acc_ff[k-1][DIV_BITS-1]};
         df = sh - {1'b0, den_ff[k-1]};
         if (!df[32]) begin
            rem_in[k] = df[31:0];
            acc_in[k] = {acc_ff[k-1][DIV_BITS-2:0], 1'b1};
         end else begin
            rem_in[k] = sh[31:0];
            acc_in[k] = {acc_ff[k-1][DIV_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff[0] <= den_mag;
         neg_ff[0] <= num_neg ^ den_neg;
         for (int k = 0; k <= DIV_BITS; k++) begin
            rem_ff[k] <= rem_in[k];
            acc_ff[k] <= acc_in[k];
         end
         for (int k = 1; k <= DIV_BITS; k++) begin
            den_ff[k] <= den_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
         end
         result_ff <= clamp_mag(acc_ff[DIV_BITS], neg_ff[DIV_BITS]);
      end
   end

   assign result = result_ff;

endmodule

// ----- rtl/hfrj_mul.sv -----
// Two-stage Q16.16 multiplier, truncating toward zero and clamped to a word.
// Depends on hfrj_pkg.
module hfrj_mul (
   input  logic                      clock,
   input  logic                      en,
   input  logic [31:0]               op_p,
   input  logic [31:0]               op_q,
   output hfrj_pkg::sat_word_type    result
);
   import hfrj_pkg::*;

   logic [63:0]  prod_ff;
   logic         neg_ff;
   sat_word_type result_ff;
   logic [31:0]  pm;
   logic [31:0]  qm;

   assign pm = mag32(op_p);
   assign qm = mag32(op_q);

   // magnitude product, then shift, sign and clamp
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff   <= {32'b0, pm} * {32'b0, qm};
         neg_ff    <= op_p[31] ^ op_q[31];
         result_ff <= clamp_mag(prod_ff[63:16], neg_ff);
      end
   end

   assign result = result_ff;

endmodule

// ----- rtl/hyperbola_fit_residual_jacobian.sv -----
// Top level: weighted residual and Jacobian of H = b*sqrt(1+(x-c)^2/a^2) + d.
// Depends on hfrj_pkg, hfrj_sqrt, hfrj_div and hfrj_mul.
//
// Usage:
//  - req_ channel carries one data point word (pos_x, meas_y, sigma); rsp_ channel
//    carries one result word (residual, four Jacobian entries, fault) per point.
//  - A word moves on either channel when valid is high and stall is low.
//  - csr_ channel writes a,b,c,d (index 0..3, Q16.16); csr_ready is always high and
//    other indexes are dropped. Write only while no point is in flight.
//  - Throughput: one point per cycle unless a held result stalls the pipeline. The
//    delay to rsp_valid is set by the longest chain of the pipelined units: x-c, divide
//    by a twice (50 stages each), multiply, divide by phi, multiply, negate.
//  - The whole pipeline advances as one; while a result waits under rsp_stall,
//    req_stall is high and nothing moves, so no word is lost or repeated.
//  - Reset clears all valid bits and loads the initial guess a=1, b=2, c=0, d=1.
//  - Zero sigma or zero a gives all-zero fields with fault set; any clamp to the
//    word range also sets fault.
module hyperbola_fit_residual_jacobian (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [31:0]   req_pos_x,
   input  logic signed [31:0]   req_meas_y,
   input  logic [30:0]          req_sigma,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [31:0]   rsp_residual,
   output logic signed [31:0]   rsp_jac_a,
   output logic signed [31:0]   rsp_jac_b,
   output logic signed [31:0]   rsp_jac_c,
   output logic signed [31:0]   rsp_jac_d,
   output logic                 rsp_fault,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [hfrj_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);
   import hfrj_pkg::*;

   // stage at which each value sits in its register
   localparam int T_DX   = 1;
   localparam int T_SQ   = 2;
   localparam int T_N    = 3;
   localparam int T_ROOT = T_N + SQRT_STEPS;
   localparam int T_PHI  = T_ROOT + DIV_LAT;
   localparam int T_M    = DIV_LAT;
   localparam int T_E    = T_DX + DIV_LAT;
   localparam int T_F    = T_E + DIV_LAT;
   localparam int T_MF   = T_F + MUL_LAT;
   localparam int T_G    = T_MF + DIV_LAT;
   localparam int T_GE   = T_G + MUL_LAT;
   localparam int T_BP   = T_PHI + MUL_LAT;
   localparam int T_SUM  = T_BP + 1;
   localparam int T_RES  = T_SUM + DIV_LAT;
   localparam int T_JB   = T_PHI + DIV_LAT;

   typedef struct packed {
      logic [31:0]      y;
      logic [SIG_W-1:0] sg;
      logic [31:0]      a;
      logic [31:0]      b;
      logic [31:0]      d;
   } ctx_type;

   function automatic sat_word_type clamp_s34(input logic [33:0] v);
      sat_word_type r;
      if (!v[33] && v[32:31] != 2'b00) begin
         r.val = W_MAX;
         r.sat = 1'b1;
      end else if (v[33] && v[32:31] != 2'b11) begin
         r.val = W_MIN;
         r.sat = 1'b1;
      end else begin
         r.val = v[31:0];
         r.sat = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [33:0] sx34(input logic [31:0] v);
      return {{2{v[31]}}, v};
   endfunction

   logic        adv;

   // configuration registers
   logic [31:0] width_a_ff;
   logic [31:0] scale_b_ff;
   logic [31:0] center_c_ff;
   logic [31:0] offset_d_ff;

   // pipeline registers
   logic        v_ff   [0:T_GE];
   logic        z_ff   [1:T_GE];
   logic        fl_ff  [1:T_GE];
   ctx_type     ctx_ff [0:T_SUM];
   logic [31:0] x_ff;
   logic [31:0] c_ff;
   logic [31:0] dx_ff;
   logic        dx_sat_ff;
   logic [63:0] sqa_ff;
   logic [63:0] sqd_ff;
   logic [63:0] n_ff;
   logic [31:0] sum_ff;
   logic        sum_sat_ff;
   logic [31:0] phi_dl_ff [T_PHI+1:T_MF];
   logic [31:0] m_dl_ff   [T_M+1:T_F];
   logic [31:0] jd_dl_ff  [T_M+1:T_GE];
   logic [31:0] e_dl_ff   [T_E+1:T_G];
   logic [31:0] jb_dl_ff  [T_JB+1:T_GE];
   logic [31:0] res_dl_ff [T_RES+1:T_GE];
   logic [31:0] g_dl_ff   [T_G+1:T_GE];

   logic        rsp_valid_ff;
   logic [31:0] rsp_residual_ff;
   logic [31:0] rsp_jac_a_ff;
   logic [31:0] rsp_jac_b_ff;
   logic [31:0] rsp_jac_c_ff;
   logic [31:0] rsp_jac_d_ff;
   logic        rsp_fault_ff;

   sat_word_type dx_in;
   sat_word_type sum_in;
   sat_word_type jc_in;
   sat_word_type ja_in;
   logic [31:0]  am_dx;
   logic [31:0]  dm_dx;
   logic [31:0]  root;
   logic [T_GE:1] hit;

   sat_word_type jd_q, m_q, e_q, phi_q, f_q, jb_q, res_q, g_q;
   sat_word_type bp_p, mf_p, ge_p;

   // whole pipeline moves unless the result register is held
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_a_ff  <= RST_WIDTH_A;
         scale_b_ff  <= RST_SCALE_B;
         center_c_ff <= RST_CENTER_C;
         offset_d_ff <= RST_OFFSET_D;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WIDTH_A:  width_a_ff  <= csr_data;
            CSR_SCALE_B:  scale_b_ff  <= csr_data;
            CSR_CENTER_C: center_c_ff <= csr_data;
            CSR_OFFSET_D: offset_d_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t <= T_GE; t++) v_ff[t] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= req_valid;
         for (int t = 1; t <= T_GE; t++) v_ff[t] <= v_ff[t-1];
         rsp_valid_ff <= v_ff[T_GE];
      end
   end

   // front end: capture, x - c, squares, sum of squares
   assign dx_in = clamp_s34(sx34(x_ff) - sx34(c_ff));
   assign am_dx = mag32(ctx_ff[T_DX].a);
   assign dm_dx = mag32(dx_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff      <= req_pos_x;
         c_ff      <= center_c_ff;
         ctx_ff[0] <= '{y: req_meas_y, sg: req_sigma, a: width_a_ff,
                        b: scale_b_ff, d: offset_d_ff};
         for (int t = 1; t <= T_SUM; t++) ctx_ff[t] <= ctx_ff[t-1];
         dx_ff     <= dx_in.val;
         dx_sat_ff <= dx_in.sat;
         sqa_ff    <= {32'b0, am_dx} * {32'b0, am_dx};
         sqd_ff    <= {32'b0, dm_dx} * {32'b0, dm_dx};
         n_ff      <= sqa_ff + sqd_ff;
         z_ff[1]   <= (ctx_ff[0].sg == '0) || (ctx_ff[0].a == '0);
         fl_ff[1]  <= 1'b0;
         for (int t = 2; t <= T_GE; t++) begin
            z_ff[t]  <= z_ff[t-1];
            fl_ff[t] <= fl_ff[t-1] | hit[t-1];
         end
      end
   end

   hfrj_sqrt u_sqrt (
      .clock(clock), .en(adv), .radicand(n_ff), .root(root)
   );

   // phi = root * 2^16 / |a|
   hfrj_div u_div_phi (
      .clock(clock), .en(adv), .num_mag(root), .num_neg(1'b0),
      .den_mag(mag32(ctx_ff[T_ROOT].a)), .den_neg(1'b0), .result(phi_q)
   );

   // 1/sigma and b/sigma
   hfrj_div u_div_jd (
      .clock(clock), .en(adv), .num_mag(Q_ONE), .num_neg(1'b0),
      .den_mag({1'b0, ctx_ff[0].sg}), .den_neg(1'b0), .result(jd_q)
   );
   hfrj_div u_div_m (
      .clock(clock), .en(adv), .num_mag(mag32(ctx_ff[0].b)),
      .num_neg(ctx_ff[0].b[31]), .den_mag({1'b0, ctx_ff[0].sg}), .den_neg(1'b0),
      .result(m_q)
   );

   // e = dx/a, f = e/a
   hfrj_div u_div_e (
      .clock(clock), .en(adv), .num_mag(mag32(dx_ff)), .num_neg(dx_ff[31]),
      .den_mag(mag32(ctx_ff[T_DX].a)), .den_neg(ctx_ff[T_DX].a[31]), .result(e_q)
   );
   hfrj_div u_div_f (
      .clock(clock), .en(adv), .num_mag(mag32(e_q.val)), .num_neg(e_q.val[31]),
      .den_mag(mag32(ctx_ff[T_E].a)), .den_neg(ctx_ff[T_E].a[31]), .result(f_q)
   );

   // phi/sigma
   hfrj_div u_div_jb (
      .clock(clock), .en(adv), .num_mag(mag32(phi_q.val)), .num_neg(phi_q.val[31]),
      .den_mag({1'b0, ctx_ff[T_PHI].sg}), .den_neg(1'b0), .result(jb_q)
   );

   // residual: (b*phi + d - y) / sigma
   hfrj_mul u_mul_bp (
      .clock(clock), .en(adv), .op_p(ctx_ff[T_PHI].b), .op_q(phi_q.val), .result(bp_p)
   );
   assign sum_in = clamp_s34(sx34(bp_p.val) + sx34(ctx_ff[T_BP].d)
                             - sx34(ctx_ff[T_BP].y));
   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff     <= sum_in.val;
         sum_sat_ff <= sum_in.sat;
      end
   end
   hfrj_div u_div_res (
      .clock(clock), .en(adv), .num_mag(mag32(sum_ff)), .num_neg(sum_ff[31]),
      .den_mag({1'b0, ctx_ff[T_SUM].sg}), .den_neg(1'b0), .result(res_q)
   );

   // g = m*f / phi, then g*e
   hfrj_mul u_mul_mf (
      .clock(clock), .en(adv), .op_p(m_dl_ff[T_F]), .op_q(f_q.val), .result(mf_p)
   );
   hfrj_div u_div_g (
      .clock(clock), .en(adv), .num_mag(mag32(mf_p.val)), .num_neg(mf_p.val[31]),
      .den_mag(mag32(phi_dl_ff[T_MF])), .den_neg(phi_dl_ff[T_MF][31]), .result(g_q)
   );
   hfrj_mul u_mul_ge (
      .clock(clock), .en(adv), .op_p(g_q.val), .op_q(e_dl_ff[T_G]), .result(ge_p)
   );

   // delay lines that align unit outputs with their consumers
   always_ff @(posedge clock) begin
      if (adv) begin
         phi_dl_ff[T_PHI+1] <= phi_q.val;
         for (int t = T_PHI + 2; t <= T_MF; t++) phi_dl_ff[t] <= phi_dl_ff[t-1];
         m_dl_ff[T_M+1] <= m_q.val;
         for (int t = T_M + 2; t <= T_F; t++) m_dl_ff[t] <= m_dl_ff[t-1];
         jd_dl_ff[T_M+1] <= jd_q.val;
         for (int t = T_M + 2; t <= T_GE; t++) jd_dl_ff[t] <= jd_dl_ff[t-1];
         e_dl_ff[T_E+1] <= e_q.val;
         for (int t = T_E + 2; t <= T_G; t++) e_dl_ff[t] <= e_dl_ff[t-1];
         jb_dl_ff[T_JB+1] <= jb_q.val;
         for (int t = T_JB + 2; t <= T_GE; t++) jb_dl_ff[t] <= jb_dl_ff[t-1];
         res_dl_ff[T_RES+1] <= res_q.val;
         for (int t = T_RES + 2; t <= T_GE; t++) res_dl_ff[t] <= res_dl_ff[t-1];
         g_dl_ff[T_G+1] <= g_q.val;
         for (int t = T_G + 2; t <= T_GE; t++) g_dl_ff[t] <= g_dl_ff[t-1];
      end
   end

   // saturation flags by the stage that holds them
   always_comb begin
      hit        = '0;
      hit[T_DX]  = dx_sat_ff;
      hit[T_M]   = jd_q.sat | m_q.sat;
      hit[T_E]   = e_q.sat;
      hit[T_PHI] = phi_q.sat;
      hit[T_BP]  = bp_p.sat;
      hit[T_SUM] = sum_sat_ff;
      hit[T_F]   = f_q.sat;
      hit[T_MF]  = mf_p.sat;
      hit[T_JB]  = jb_q.sat;
      hit[T_RES] = res_q.sat;
      hit[T_G]   = g_q.sat;
      hit[T_GE]  = ge_p.sat;
   end

   // final negations and result register
   assign jc_in = clamp_s34(34'd0 - sx34(g_dl_ff[T_GE]));
   assign ja_in = clamp_s34(34'd0 - sx34(ge_p.val));

   always_ff @(posedge clock) begin
      if (adv) begin
         if (z_ff[T_GE]) begin
            rsp_residual_ff <= '0;
            rsp_jac_a_ff    <= '0;
            rsp_jac_b_ff    <= '0;
            rsp_jac_c_ff    <= '0;
            rsp_jac_d_ff    <= '0;
            rsp_fault_ff    <= 1'b1;
         end else begin
            rsp_residual_ff <= res_dl_ff[T_GE];
            rsp_jac_a_ff    <= ja_in.val;
            rsp_jac_b_ff    <= jb_dl_ff[T_GE];
            rsp_jac_c_ff    <= jc_in.val;
            rsp_jac_d_ff    <= jd_dl_ff[T_GE];
            rsp_fault_ff    <= fl_ff[T_GE] | hit[T_GE] | jc_in.sat | ja_in.sat;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_residual = rsp_residual_ff;
   assign rsp_jac_a    = rsp_jac_a_ff;
   assign rsp_jac_b    = rsp_jac_b_ff;
   assign rsp_jac_c    = rsp_jac_c_ff;
   assign rsp_jac_d    = rsp_jac_d_ff;
   assign rsp_fault    = rsp_fault_ff;

`ifndef NO_ASSERTIONS
   // a held result must hold back the input side
   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input not stalled while result is held");

   // phi/sigma and 1/sigma can never be negative
   a_jac_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_jac_b[31] && !rsp_jac_d[31])
      else $error("negative jac_b or jac_d");

   // phi is at least one, so phi/sigma is never below 1/sigma
   a_jac_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_jac_b >= rsp_jac_d)
      else $error("jac_b below jac_d");
`endif

endmodule
